// File: hw/rtl/trx86rf_pkg.sv
package trx86rf_pkg;

  // Operation codes carried on the kind field of an input beat.
  typedef enum logic [3:0] {
    KIND_RDBYTE    = 4'd0,
    KIND_RDWORD    = 4'd1,
    KIND_RDSEG     = 4'd2,
    KIND_WRBYTE    = 4'd3,
    KIND_WRWORD    = 4'd4,
    KIND_WRWORDREL = 4'd5,
    KIND_WRSEG     = 4'd6,
    KIND_WRSEGREL  = 4'd7,
    KIND_UNDEFWORD = 4'd8,
    KIND_UNDEFSEG  = 4'd9,
    KIND_UNDEFALL  = 4'd10,
    KIND_MERGEWORD = 4'd11,
    KIND_MERGESEG  = 4'd12,
    KIND_CHECKWORD = 4'd13,
    KIND_CHECKSEG  = 4'd14
  } kind_t;

  localparam int unsigned NUM_BYTE_HALVES = 8;
  localparam int unsigned NUM_PTR_WORDS   = 4;
  localparam int unsigned NUM_SEG_WORDS   = 4;
  localparam int unsigned NUM_TAG_SLOTS   = 16;
  localparam int unsigned NUM_REL_BITS    = 12;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

endpackage

// File: hw/rtl/tracked_x86_register_file_unit.sv
// A start beat is captured in the input register, and its result is then loaded into the result register.
// Throughput: one beat per cycle; busy is held low, so start may be high in every cycle.
// Each beat reads the register state as left by every beat taken before it.
// The receiver cannot stall: out_valid is high for exactly one cycle per result.
// Reset (rst_n low, synchronous) clears all values, source tags and relative bits.
// The beat in flight during reset is dropped and no result is produced for it.
module tracked_x86_register_file_unit #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [3:0]               in_kind,
  input  logic [2:0]               in_index,
  input  trx86rf_pkg::word_t       in_value,
  input  logic [15:0]              in_tag,
  input  logic                     in_other_low_defined,
  input  logic                     in_other_high_defined,
  input  logic                     in_other_relative,
  output logic                     out_valid,
  output trx86rf_pkg::word_t       out_data_out,
  output logic                     out_is_defined,
  output logic                     out_is_relative,
  output logic [15:0]              out_source_tag,
  output logic                     out_would_change
);
  import trx86rf_pkg::*;

  typedef logic [TAG_BITS-1:0] tag_t;

  // The block has no multi-cycle work, so it never refuses a beat.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Input register. The beat is captured here and processed in the next cycle
  // against the architectural state, which is updated on the same edge that
  // loads the result register. A following beat therefore sees the update.
  // ---------------------------------------------------------------------------
  logic        in_valid_r;
  logic [3:0]  kind_r;
  logic [2:0]  index_r;
  word_t       value_r;
  logic [15:0] tag_r;
  logic        olo_r;
  logic        ohi_r;
  logic        orel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind_r  <= in_kind;
      index_r <= in_index;
      value_r <= in_value;
      tag_r   <= in_tag;
      olo_r   <= in_other_low_defined;
      ohi_r   <= in_other_high_defined;
      orel_r  <= in_other_relative;
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state. Byte halves are stored in slot order AL AH CL CH DL
  // DH BL BH. Tag slots 0 to 7 belong to the byte halves, 8 to 11 to SP..DI
  // and 12 to 15 to the segment registers. Relative bit i belongs to word
  // register i and bit 8+s to segment register s. A zero tag means undefined.
  // ---------------------------------------------------------------------------
  byte_t                byte_r  [NUM_BYTE_HALVES];
  word_t                ptr_r   [NUM_PTR_WORDS];
  word_t                seg_r   [NUM_SEG_WORDS];
  tag_t                 stag_r  [NUM_TAG_SLOTS];
  logic [NUM_REL_BITS-1:0] rel_r;

  byte_t                byte_nxt [NUM_BYTE_HALVES];
  word_t                ptr_nxt  [NUM_PTR_WORDS];
  word_t                seg_nxt  [NUM_SEG_WORDS];
  tag_t                 stag_nxt [NUM_TAG_SLOTS];
  logic [NUM_REL_BITS-1:0] rel_nxt;

  // Result register.
  logic        out_valid_r;
  word_t       data_r,   data_nxt;
  logic        def_r,    def_nxt;
  logic        relo_r,   relo_nxt;
  logic [15:0] otag_r,   otag_nxt;
  logic        chg_r,    chg_nxt;

  // The incoming tag is cut or zero-extended to the stored tag width, and a
  // stored tag is shown on the 16-bit result port by its low bits.
  logic [TAG_BITS+15:0] tag_ext;
  tag_t                 wr_tag;
  tag_t                 rd_tag;
  logic [TAG_BITS+15:0] rd_tag_ext;

  assign tag_ext    = {{TAG_BITS{1'b0}}, tag_r};
  assign wr_tag     = tag_ext[TAG_BITS-1:0];
  assign rd_tag_ext = {16'b0, rd_tag};

  // Addressing derived from the index field.
  logic [3:0] byte_slot;   // byte half for byte operations
  logic [3:0] lo_slot;     // low half of a split word
  logic [3:0] hi_slot;     // high half of a split word
  logic [3:0] ptr_slot;    // tag slot of SP..DI
  logic [3:0] seg_slot;    // tag slot of a segment register
  logic [3:0] word_rbit;   // relative bit of a word register
  logic [1:0] sidx;
  logic       split;

  assign sidx      = index_r[1:0];
  assign split     = ~index_r[2];
  assign byte_slot = {1'b0, index_r[1:0], index_r[2]};
  assign lo_slot   = {1'b0, index_r[1:0], 1'b0};
  assign hi_slot   = {1'b0, index_r[1:0], 1'b1};
  assign ptr_slot  = {2'b10, index_r[1:0]};
  assign seg_slot  = {2'b11, sidx};
  assign word_rbit = {1'b0, index_r};

  always_comb begin
    logic  dlo;
    logic  dhi;
    logic  ch;
    logic  word_rel;
    logic  seg_rel;
    kind_t kind;

    byte_nxt = byte_r;
    ptr_nxt  = ptr_r;
    seg_nxt  = seg_r;
    stag_nxt = stag_r;
    rel_nxt  = rel_r;
    data_nxt = '0;
    def_nxt  = 1'b0;
    relo_nxt = 1'b0;
    rd_tag   = '0;
    chg_nxt  = 1'b0;
    dlo      = 1'b0;
    dhi      = 1'b0;
    ch       = 1'b0;
    word_rel = rel_r[word_rbit];
    seg_rel  = rel_r[{2'b10, sidx}];
    kind     = kind_t'(kind_r);

    if (in_valid_r) begin
      unique case (kind)
        KIND_RDBYTE: begin
          data_nxt = {8'h00, byte_r[byte_slot[2:0]]};
          rd_tag   = stag_r[byte_slot];
          def_nxt  = (rd_tag != '0);
        end
        KIND_RDWORD: begin
          if (split) begin
            data_nxt = {byte_r[hi_slot[2:0]], byte_r[lo_slot[2:0]]};
            def_nxt  = (stag_r[lo_slot] != '0) && (stag_r[hi_slot] != '0);
            rd_tag   = (stag_r[lo_slot] == stag_r[hi_slot]) ? stag_r[lo_slot] : '0;
          end else begin
            data_nxt = ptr_r[sidx];
            rd_tag   = stag_r[ptr_slot];
            def_nxt  = (rd_tag != '0);
          end
          relo_nxt = def_nxt && word_rel;
        end
        KIND_RDSEG: begin
          data_nxt = seg_r[sidx];
          rd_tag   = stag_r[seg_slot];
          def_nxt  = (rd_tag != '0);
          relo_nxt = def_nxt && seg_rel;
        end
        KIND_WRBYTE: begin
          byte_nxt[byte_slot[2:0]] = value_r[7:0];
          stag_nxt[byte_slot]      = wr_tag;
        end
        KIND_WRWORD, KIND_WRWORDREL: begin
          if (split) begin
            byte_nxt[lo_slot[2:0]] = value_r[7:0];
            byte_nxt[hi_slot[2:0]] = value_r[15:8];
            stag_nxt[lo_slot]      = wr_tag;
            stag_nxt[hi_slot]      = wr_tag;
          end else begin
            ptr_nxt[sidx]      = value_r;
            stag_nxt[ptr_slot] = wr_tag;
          end
          rel_nxt[word_rbit] = (kind == KIND_WRWORDREL);
        end
        KIND_WRSEG, KIND_WRSEGREL: begin
          seg_nxt[sidx]             = value_r;
          stag_nxt[seg_slot]        = wr_tag;
          rel_nxt[{2'b10, sidx}]    = (kind == KIND_WRSEGREL);
        end
        KIND_UNDEFWORD: begin
          if (split) begin
            stag_nxt[lo_slot] = '0;
            stag_nxt[hi_slot] = '0;
          end else begin
            stag_nxt[ptr_slot] = '0;
          end
        end
        KIND_UNDEFSEG: begin
          stag_nxt[seg_slot] = '0;
        end
        KIND_UNDEFALL: begin
          for (int i = 0; i < NUM_TAG_SLOTS; i++) begin
            stag_nxt[i] = '0;
          end
        end
        KIND_MERGEWORD, KIND_CHECKWORD: begin
          if (split) begin
            // Each half drops out if the other state disagrees on it; a
            // surviving pair then drops out together on a relative mismatch.
            dlo = (stag_r[lo_slot] != '0);
            dhi = (stag_r[hi_slot] != '0);
            if (dlo && (!olo_r || byte_r[lo_slot[2:0]] != value_r[7:0])) begin
              dlo = 1'b0;
              ch  = 1'b1;
            end
            if (dhi && (!ohi_r || byte_r[hi_slot[2:0]] != value_r[15:8])) begin
              dhi = 1'b0;
              ch  = 1'b1;
            end
            if (dlo && dhi && (word_rel != orel_r)) begin
              dlo = 1'b0;
              dhi = 1'b0;
              ch  = 1'b1;
            end
            if (kind == KIND_MERGEWORD) begin
              if (!dlo) stag_nxt[lo_slot] = '0;
              if (!dhi) stag_nxt[hi_slot] = '0;
            end
          end else begin
            ch = (stag_r[ptr_slot] != '0) &&
                 (!olo_r || ptr_r[sidx] != value_r || word_rel != orel_r);
            if (ch && kind == KIND_MERGEWORD) begin
              stag_nxt[ptr_slot] = '0;
            end
          end
          chg_nxt = ch;
        end
        KIND_MERGESEG, KIND_CHECKSEG: begin
          ch = (stag_r[seg_slot] != '0) &&
               (!olo_r || seg_r[sidx] != value_r || seg_rel != orel_r);
          if (ch && kind == KIND_MERGESEG) begin
            stag_nxt[seg_slot] = '0;
          end
          chg_nxt = ch;
        end
        default: begin
          // The unused code leaves the state alone and returns zeros.
        end
      endcase
    end
    otag_nxt = rd_tag_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BYTE_HALVES; i++) begin
        byte_r[i] <= '0;
      end
      for (int i = 0; i < NUM_PTR_WORDS; i++) begin
        ptr_r[i] <= '0;
      end
      for (int i = 0; i < NUM_SEG_WORDS; i++) begin
        seg_r[i] <= '0;
      end
      for (int i = 0; i < NUM_TAG_SLOTS; i++) begin
        stag_r[i] <= '0;
      end
      rel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      byte_r      <= byte_nxt;
      ptr_r       <= ptr_nxt;
      seg_r       <= seg_nxt;
      stag_r      <= stag_nxt;
      rel_r       <= rel_nxt;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      data_r <= data_nxt;
      def_r  <= def_nxt;
      relo_r <= relo_nxt;
      otag_r <= otag_nxt;
      chg_r  <= chg_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = data_r;
  assign out_is_defined   = def_r;
  assign out_is_relative  = relo_r;
  assign out_source_tag   = otag_r;
  assign out_would_change = chg_r;

endmodule
